FILE: sv/gha_pkg.sv
// Package for the generational handle allocator.
// Holds field widths, operation, status and slot state codes, and shared types.
// No dependencies.
package gha_pkg;

   localparam int KIND_W   = 4;
   localparam int HIDX_W   = 10;
   localparam int GEN_W    = 32;
   localparam int EPOCH_W  = 64;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 11;

   localparam logic [KIND_W-1:0] K_RESERVE     = 4'd0;
   localparam logic [KIND_W-1:0] K_CREATE      = 4'd1;
   localparam logic [KIND_W-1:0] K_PUBLISH     = 4'd2;
   localparam logic [KIND_W-1:0] K_ROLLBACK    = 4'd3;
   localparam logic [KIND_W-1:0] K_DESTROY     = 4'd4;
   localparam logic [KIND_W-1:0] K_IS_ALIVE    = 4'd5;
   localparam logic [KIND_W-1:0] K_IS_RESERVED = 4'd6;
   localparam logic [KIND_W-1:0] K_IS_CURRENT  = 4'd7;
   localparam logic [KIND_W-1:0] K_RETIRE      = 4'd8;

   localparam logic [STATUS_W-1:0] RC_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] RC_INVALID   = 2'd1;
   localparam logic [STATUS_W-1:0] RC_STATE     = 2'd2;
   localparam logic [STATUS_W-1:0] RC_EXHAUSTED = 2'd3;

   localparam logic [1:0] ST_FREE     = 2'd0;
   localparam logic [1:0] ST_RESERVED = 2'd1;
   localparam logic [1:0] ST_ALIVE    = 2'd2;
   localparam logic [1:0] ST_PENDING  = 2'd3;

   typedef struct packed {
      logic [GEN_W-1:0]   gen;
      logic [1:0]         st;
      logic [EPOCH_W-1:0] ep;
   } slot_type;

   typedef struct packed {
      logic push;
      logic pop;
   } q_ctrl_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_stat_type;

endpackage

FILE: sv/gha_if.sv
// Channel interfaces for the request and response beats.
// Depends on gha_pkg for field widths.
interface gha_req_if;
   logic                         valid;
   logic                         ready;
   logic [gha_pkg::KIND_W-1:0]   kind;
   logic [gha_pkg::HIDX_W-1:0]   handle_index;
   logic [gha_pkg::GEN_W-1:0]    handle_generation;
   logic [gha_pkg::EPOCH_W-1:0]  epoch;
   modport source (output valid, kind, handle_index, handle_generation, epoch, input ready);
   modport sink   (input valid, kind, handle_index, handle_generation, epoch, output ready);
endinterface

interface gha_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [gha_pkg::STATUS_W-1:0]  status;
   logic [gha_pkg::HIDX_W-1:0]    out_index;
   logic [gha_pkg::GEN_W-1:0]     out_generation;
   logic                          answer;
   logic [gha_pkg::COUNT_W-1:0]   retired_count;
   modport source (output valid, status, out_index, out_generation, answer, retired_count,
                   input ready);
   modport sink   (input valid, status, out_index, out_generation, answer, retired_count,
                   output ready);
endinterface

FILE: sv/gha_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module gha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: sv/gha_free_queue.sv
// Circular queue of freed slot indices, built on one RAM.
// Depends on gha_pkg and gha_ram.
module gha_free_queue #(
   parameter int DEPTH = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  gha_pkg::q_ctrl_type        ctrl,
   input  logic [$clog2(DEPTH)-1:0]   push_idx,
   output logic [$clog2(DEPTH)-1:0]   pop_idx,
   output gha_pkg::q_stat_type        stat
);
   import gha_pkg::*;
   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [IW-1:0] head_ff, tail_ff;
   logic [CW-1:0] count_ff;
   logic          do_push;

   // A push into a full queue is dropped.
   assign do_push    = ctrl.push && !stat.full;
   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CW'(DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            tail_ff <= (tail_ff == IW'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
         end
         if (ctrl.pop) begin
            head_ff <= (head_ff == IW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
         end
         if (do_push && !ctrl.pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (ctrl.pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   gha_ram #(.WIDTH(IW), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (do_push),
      .wr_addr (tail_ff),
      .wr_data (push_idx),
      .rd_en   (ctrl.pop),
      .rd_addr (head_ff),
      .rd_data (pop_idx)
   );
endmodule

FILE: sv/generational_handle_allocator.sv
// Generational handle allocator: slot table RAM, free-index queue, one sequencer.
// Path: decode, done (fresh reserve/create, invalid or null handle, unknown kind); decode,
// exec, done (other handle operations); decode, pop wait, exec, done (reserve/create from the
// free queue); decode, scan per slot past zero, done (retire). The next beat is accepted the
// cycle after the response loads; an untaken response holds the next item in its last state.
// Synchronous reset empties the free queue and holds slot zero; no clearing pass.
module generational_handle_allocator #(
   parameter int MAX_SLOTS = 1024
) (
   input  logic    clock,
   input  logic    reset,
   gha_req_if.sink   req_ch,
   gha_rsp_if.source rsp_ch
);
   import gha_pkg::*;
   localparam int IW   = $clog2(MAX_SLOTS);
   localparam int SW   = $clog2(MAX_SLOTS + 1);
   localparam int CMPW = (SW > HIDX_W) ? SW : HIDX_W;

   typedef enum logic [2:0] {
      S_IDLE, S_DECODE, S_POP_WAIT, S_EXEC, S_SCAN_RD, S_SCAN_EV, S_DONE
   } state_type;

   state_type            state_ff;
   logic [KIND_W-1:0]    kind_ff;
   logic [HIDX_W-1:0]    hidx_ff;
   logic [GEN_W-1:0]     hgen_ff;
   logic [EPOCH_W-1:0]   epoch_ff;
   logic [IW-1:0]        addr_ff;
   logic [SW-1:0]        in_use_ff;
   logic [SW-1:0]        scan_ff;
   logic [STATUS_W-1:0]  status_ff;
   logic [HIDX_W-1:0]    oidx_ff;
   logic [GEN_W-1:0]     ogen_ff;
   logic                 ans_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic                 rsp_valid_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [HIDX_W-1:0]    rsp_idx_ff;
   logic [GEN_W-1:0]     rsp_gen_ff;
   logic                 rsp_ans_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;

   logic                 slot_wr_en, slot_rd_en;
   logic [IW-1:0]        slot_wr_addr, slot_rd_addr;
   slot_type             slot_wr_data, slot_rd_data;
   q_ctrl_type           q_ctrl;
   q_stat_type           q_stat;
   logic [IW-1:0]        q_push_idx, q_pop_idx;

   logic                 handle_ok, match, is_reserve, retire_hit;
   logic [GEN_W-1:0]     reserve_gen;
   logic [SW-1:0]        scan_next;

   assign handle_ok  = (hidx_ff != '0) && (CMPW'(hidx_ff) < CMPW'(in_use_ff));
   assign match      = (slot_rd_data.gen == hgen_ff);
   assign is_reserve = (kind_ff == K_RESERVE) || (kind_ff == K_CREATE);
   assign reserve_gen = (slot_rd_data.gen == '0) ? GEN_W'(1) : slot_rd_data.gen;
   assign retire_hit = (slot_rd_data.st == ST_PENDING) && (slot_rd_data.ep <= epoch_ff);
   assign scan_next  = scan_ff + 1'b1;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.out_index = rsp_idx_ff;
   assign rsp_ch.out_generation = rsp_gen_ff;
   assign rsp_ch.answer = rsp_ans_ff;
   assign rsp_ch.retired_count = rsp_count_ff;

   // Slot table and queue control, decoded from the sequencer state.
   always_comb begin
      slot_wr_en   = 1'b0;
      slot_wr_addr = addr_ff;
      slot_wr_data = '{gen: slot_rd_data.gen, st: slot_rd_data.st, ep: slot_rd_data.ep};
      slot_rd_en   = 1'b0;
      slot_rd_addr = IW'(hidx_ff);
      q_ctrl       = '{push: 1'b0, pop: 1'b0};
      q_push_idx   = addr_ff;
      unique case (state_ff)
         S_DECODE: begin
            if (is_reserve) begin
               if (!q_stat.empty) begin
                  q_ctrl.pop = 1'b1;
               end else if (in_use_ff < SW'(MAX_SLOTS)) begin
                  slot_wr_en   = 1'b1;
                  slot_wr_addr = IW'(in_use_ff);
                  slot_wr_data = '{gen: GEN_W'(1),
                                   st: (kind_ff == K_CREATE) ? ST_ALIVE : ST_RESERVED,
                                   ep: '0};
               end
            end else if (handle_ok && kind_ff >= K_PUBLISH && kind_ff <= K_IS_CURRENT) begin
               slot_rd_en = 1'b1;
            end
         end
         S_POP_WAIT: begin
            slot_rd_en   = 1'b1;
            slot_rd_addr = q_pop_idx;
         end
         S_EXEC: begin
            if (is_reserve) begin
               slot_wr_en   = 1'b1;
               slot_wr_data = '{gen: reserve_gen,
                                st: (kind_ff == K_CREATE) ? ST_ALIVE : ST_RESERVED,
                                ep: '0};
            end else if (match && kind_ff == K_PUBLISH && slot_rd_data.st == ST_RESERVED) begin
               slot_wr_en      = 1'b1;
               slot_wr_data.st = ST_ALIVE;
            end else if (match && kind_ff == K_ROLLBACK && slot_rd_data.st == ST_RESERVED) begin
               slot_wr_en   = 1'b1;
               slot_wr_data = '{gen: slot_rd_data.gen + 1'b1, st: ST_FREE, ep: '0};
               q_ctrl.push  = 1'b1;
            end else if (match && kind_ff == K_DESTROY && slot_rd_data.st == ST_ALIVE) begin
               slot_wr_en   = 1'b1;
               slot_wr_data = '{gen: slot_rd_data.gen + 1'b1, st: ST_PENDING, ep: epoch_ff};
            end
         end
         S_SCAN_RD: begin
            slot_rd_en   = 1'b1;
            slot_rd_addr = scan_ff[IW-1:0];
         end
         S_SCAN_EV: begin
            if (retire_hit) begin
               slot_wr_en   = 1'b1;
               slot_wr_addr = scan_ff[IW-1:0];
               slot_wr_data = '{gen: slot_rd_data.gen, st: ST_FREE, ep: '0};
               q_ctrl.push  = 1'b1;
               q_push_idx   = scan_ff[IW-1:0];
            end
         end
         S_IDLE, S_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         in_use_ff    <= SW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         // In the done state the response register is reloaded instead.
         if (rsp_valid_ff && rsp_ch.ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_ch.valid) begin
                  kind_ff  <= req_ch.kind;
                  hidx_ff  <= req_ch.handle_index;
                  hgen_ff  <= req_ch.handle_generation;
                  epoch_ff <= req_ch.epoch;
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               status_ff <= RC_OK;
               oidx_ff   <= '0;
               ogen_ff   <= '0;
               ans_ff    <= 1'b0;
               count_ff  <= '0;
               addr_ff   <= IW'(hidx_ff);
               state_ff  <= S_DONE;
               if (is_reserve) begin
                  if (!q_stat.empty) begin
                     state_ff <= S_POP_WAIT;
                  end else if (in_use_ff < SW'(MAX_SLOTS)) begin
                     oidx_ff   <= HIDX_W'(in_use_ff[IW-1:0]);
                     ogen_ff   <= GEN_W'(1);
                     in_use_ff <= in_use_ff + 1'b1;
                  end else begin
                     status_ff <= RC_EXHAUSTED;
                  end
               end else if (kind_ff == K_RETIRE) begin
                  scan_ff <= SW'(1);
                  if (in_use_ff > SW'(1)) begin
                     state_ff <= S_SCAN_RD;
                  end
               end else if (kind_ff >= K_PUBLISH && kind_ff <= K_IS_CURRENT) begin
                  if (handle_ok) begin
                     state_ff <= S_EXEC;
                  end else if (kind_ff <= K_DESTROY && !(kind_ff == K_DESTROY &&
                                                         hidx_ff == '0)) begin
                     status_ff <= RC_INVALID;
                  end
               end
            end
            S_POP_WAIT: begin
               addr_ff  <= q_pop_idx;
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               state_ff <= S_DONE;
               if (is_reserve) begin
                  oidx_ff <= HIDX_W'(addr_ff);
                  ogen_ff <= reserve_gen;
               end else if (kind_ff == K_IS_ALIVE) begin
                  ans_ff <= match && (slot_rd_data.st == ST_ALIVE);
               end else if (kind_ff == K_IS_RESERVED) begin
                  ans_ff <= match && (slot_rd_data.st == ST_RESERVED);
               end else if (kind_ff == K_IS_CURRENT) begin
                  ans_ff <= match && (slot_rd_data.st == ST_ALIVE ||
                                      slot_rd_data.st == ST_RESERVED);
               end else if (!match || slot_rd_data.st !=
                            ((kind_ff == K_DESTROY) ? ST_ALIVE : ST_RESERVED)) begin
                  status_ff <= RC_STATE;
               end
            end
            S_SCAN_RD: begin
               state_ff <= S_SCAN_EV;
            end
            S_SCAN_EV: begin
               if (retire_hit) begin
                  count_ff <= count_ff + 1'b1;
               end
               scan_ff  <= scan_next;
               state_ff <= (scan_next < in_use_ff) ? S_SCAN_RD : S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= status_ff;
                  rsp_idx_ff    <= oidx_ff;
                  rsp_gen_ff    <= ogen_ff;
                  rsp_ans_ff    <= ans_ff;
                  rsp_count_ff  <= count_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   gha_ram #(.WIDTH($bits(slot_type)), .DEPTH(MAX_SLOTS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (slot_wr_data),
      .rd_en   (slot_rd_en),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_rd_data)
   );

   gha_free_queue #(.DEPTH(MAX_SLOTS)) u_free_queue (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (q_ctrl),
      .push_idx (q_push_idx),
      .pop_idx  (q_pop_idx),
      .stat     (q_stat)
   );

   a_in_use_range: assert property (@(posedge clock) disable iff (reset)
      in_use_ff >= SW'(1) && in_use_ff <= SW'(MAX_SLOTS))
      else $error("slots in use out of range");

   a_exhausted_only_when_full: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && status_ff == RC_EXHAUSTED |->
         q_stat.empty && in_use_ff == SW'(MAX_SLOTS))
      else $error("exhausted reported with slots available");

   a_no_push_and_pop: assert property (@(posedge clock) disable iff (reset)
      !(q_ctrl.push && q_ctrl.pop))
      else $error("free queue pushed and popped in one cycle");

   a_scan_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN_RD |-> scan_ff != '0 && scan_ff < in_use_ff)
      else $error("retire scan beyond slots in use");

   a_accept_starts_work: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> state_ff == S_DECODE)
      else $error("accepted beat not decoded");
endmodule
